>>> rtl/fse_pkg.sv
// Shared constants and codes for the stack engine.
package fse_pkg;

  localparam int unsigned STACK_DEPTH_DEF  = 256;
  localparam int unsigned MEMORY_WORDS_DEF = 1024;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned CMD_W            = 5;
  localparam int unsigned STATUS_W         = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 5'd0,
    CMD_POP   = 5'd1,
    CMD_ADD   = 5'd2,
    CMD_SUB   = 5'd3,
    CMD_MUL   = 5'd4,
    CMD_DIV   = 5'd5,
    CMD_AND   = 5'd6,
    CMD_OR    = 5'd7,
    CMD_XOR   = 5'd8,
    CMD_SHL   = 5'd9,
    CMD_SHR   = 5'd10,
    CMD_TUCK  = 5'd11,
    CMD_PICK  = 5'd12,
    CMD_ROLL  = 5'd13,
    CMD_OVER2 = 5'd14,
    CMD_DROP2 = 5'd15,
    CMD_SWAP2 = 5'd16,
    CMD_STORE = 5'd17,
    CMD_LOAD  = 5'd18
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_ADDR  = 3'd4,
    ST_INDEX = 3'd5
  } status_e;

endpackage

>>> rtl/forth_stack_engine.sv
// Integer data stack engine: sequencer, stack memory, data memory and divider.
//
// Each command is accepted, worked through a short sequence of read-modify-write steps on a
// one-port-read, one-port-write stack memory (read data arrives in the cycle after the address),
// and its one result is placed in an output register. Division runs on a one-bit-a-cycle
// divider. The next command is taken in the cycle after the result is loaded, and a result
// that waits on a stalled output holds off the input. After reset the data memory is swept
// to zero, one word a cycle, so no command is accepted until the sweep is done; the mode
// register can be written at any time the engine is idle.
module forth_stack_engine #(
  parameter int unsigned STACK_DEPTH  = fse_pkg::STACK_DEPTH_DEF,
  parameter int unsigned MEMORY_WORDS = fse_pkg::MEMORY_WORDS_DEF,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          front_mode_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fse_pkg::CMD_W-1:0]     command_i,
  input  logic signed [31:0]            operand_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fse_pkg::STATUS_W-1:0]  status_o,
  output logic signed [31:0]            popped_value_o,
  output logic [CW-1:0]                 depth_o
);

  localparam int unsigned PW  = $clog2(STACK_DEPTH);
  localparam int unsigned DAW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [2:0]  ph_q, ph_d;
  logic [fse_pkg::CMD_W-1:0] cmd_q;
  logic [31:0] opnd_q;
  logic [PW-1:0] fp_q, fp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic        mode_q;
  logic [31:0] a_q, a_d, b_q, b_d, r_q, r_d, pv_q, pv_d;
  logic [PW-1:0] k_q, k_d;
  fse_pkg::status_e st_q, st_d;
  logic [DAW-1:0] clr_q, clr_d;
  logic [31:0] dv_rem_q, dv_rem_d, dv_quo_q, dv_quo_d;
  logic [5:0]  dv_n_q, dv_n_d;
  logic        dv_neg_q, dv_neg_d;

  logic        out_valid_q;
  fse_pkg::status_e out_st_q;
  logic [31:0] out_pv_q;
  logic [CW-1:0] out_depth_q;

  logic [31:0] stk_mem [STACK_DEPTH];
  logic [31:0] dmem [MEMORY_WORDS];
  logic [31:0] stk_rd_q, dm_rd_q;
  logic        stk_we, dm_we;
  logic [PW-1:0] stk_waddr, stk_raddr;
  logic [31:0] stk_wdata, dm_wdata;
  logic [DAW-1:0] dm_waddr, dm_raddr;

  logic [PW-1:0] fp_inc, fp_dec, pop_slot, push_slot;
  logic [PW-1:0] back0, back1, back2, back3;
  logic          in_acc, out_load, fin;
  logic          idx_bad, addr_bad;
  logic [4:0]    sh;
  logic [32:0]   rem_sh, rem_diff;
  logic [31:0]   quo_nx, rd_mag, b_mag;

  function automatic logic [PW-1:0] slot_f(input logic [PW-1:0] f, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = {{(CW + 1 - PW){1'b0}}, f} + {1'b0, p};
    if (s >= (CW + 1)'(STACK_DEPTH)) s = s - (CW + 1)'(STACK_DEPTH);
    return s[PW-1:0];
  endfunction

  function automatic logic [CW-1:0] bpos(input logic [CW-1:0] c, input logic [PW-1:0] k);
    return c - CW'(1) - CW'(k);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign popped_value_o = out_pv_q;
  assign depth_o        = out_depth_q;

  assign fp_inc    = (fp_q == PW'(STACK_DEPTH - 1)) ? '0 : fp_q + 1'b1;
  assign fp_dec    = (fp_q == '0) ? PW'(STACK_DEPTH - 1) : fp_q - 1'b1;
  assign pop_slot  = mode_q ? fp_q : slot_f(fp_q, cnt_q - CW'(1));
  assign push_slot = mode_q ? fp_dec : slot_f(fp_q, cnt_q);
  assign back0     = slot_f(fp_q, bpos(cnt_q, PW'(0)));
  assign back1     = slot_f(fp_q, bpos(cnt_q, PW'(1)));
  assign back2     = slot_f(fp_q, bpos(cnt_q, PW'(2)));
  assign back3     = slot_f(fp_q, bpos(cnt_q, PW'(3)));

  assign idx_bad  = opnd_q[31] || (opnd_q >= 32'(cnt_q));
  assign addr_bad = a_q[31] || (a_q >= 32'(MEMORY_WORDS));
  assign sh       = b_q[4:0];
  assign rd_mag   = stk_rd_q[31] ? 32'(-stk_rd_q) : stk_rd_q;
  assign b_mag    = b_q[31] ? 32'(-b_q) : b_q;
  assign rem_sh   = {dv_rem_q, dv_quo_q[31]};
  assign rem_diff = rem_sh - {1'b0, b_q};
  assign quo_nx   = {dv_quo_q[30:0], !rem_diff[32]};

  always_comb begin
    state_d   = state_q;
    ph_d      = ph_q;
    fp_d      = fp_q;
    cnt_d     = cnt_q;
    a_d       = a_q;
    b_d       = b_q;
    r_d       = r_q;
    k_d       = k_q;
    st_d      = st_q;
    pv_d      = pv_q;
    clr_d     = clr_q;
    dv_rem_d  = dv_rem_q;
    dv_quo_d  = dv_quo_q;
    dv_n_d    = dv_n_q;
    dv_neg_d  = dv_neg_q;
    stk_we    = 1'b0;
    stk_waddr = push_slot;
    stk_wdata = r_q;
    stk_raddr = pop_slot;
    dm_we     = 1'b0;
    dm_waddr  = a_q[DAW-1:0];
    dm_wdata  = stk_rd_q;
    dm_raddr  = stk_rd_q[DAW-1:0];
    fin       = 1'b0;

    case (state_q)
      S_CLEAR: begin
        dm_we    = 1'b1;
        dm_waddr = clr_q;
        dm_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == DAW'(MEMORY_WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
          ph_d    = '0;
          st_d    = fse_pkg::ST_OK;
          pv_d    = '0;
        end
      end
      S_EXEC: begin
        ph_d = ph_q + 1'b1;
        case (cmd_q)
          fse_pkg::CMD_PUSH: begin
            fin = 1'b1;
            if (cnt_q == CW'(STACK_DEPTH)) begin
              st_d = fse_pkg::ST_OVER;
            end else begin
              stk_we    = 1'b1;
              stk_wdata = opnd_q;
              cnt_d     = cnt_q + 1'b1;
              if (mode_q) fp_d = fp_dec;
            end
          end
          fse_pkg::CMD_POP: begin
            if (ph_q == 3'd0) begin
              if (cnt_q == '0) begin
                st_d = fse_pkg::ST_UNDER;
                fin  = 1'b1;
              end else begin
                cnt_d = cnt_q - 1'b1;
                if (mode_q) fp_d = fp_inc;
              end
            end else begin
              pv_d = stk_rd_q;
              fin  = 1'b1;
            end
          end
          fse_pkg::CMD_ADD, fse_pkg::CMD_SUB, fse_pkg::CMD_MUL, fse_pkg::CMD_DIV,
          fse_pkg::CMD_AND, fse_pkg::CMD_OR, fse_pkg::CMD_XOR, fse_pkg::CMD_SHL,
          fse_pkg::CMD_SHR: begin
            case (ph_q)
              3'd0: begin
                // Bitwise and shift commands check the depth before popping anything.
                if (cnt_q == '0 || (cmd_q >= fse_pkg::CMD_AND && cnt_q < CW'(2))) begin
                  st_d = fse_pkg::ST_UNDER;
                  fin  = 1'b1;
                end else begin
                  cnt_d = cnt_q - 1'b1;
                  if (mode_q) fp_d = fp_inc;
                end
              end
              3'd1: begin
                b_d = stk_rd_q;
                if (cmd_q == fse_pkg::CMD_DIV && stk_rd_q == '0) begin
                  st_d = fse_pkg::ST_DIVZ;
                  fin  = 1'b1;
                end else if (cnt_q == '0) begin
                  st_d = fse_pkg::ST_UNDER;
                  fin  = 1'b1;
                end else begin
                  cnt_d = cnt_q - 1'b1;
                  if (mode_q) fp_d = fp_inc;
                end
              end
              3'd2: begin
                case (cmd_q)
                  fse_pkg::CMD_ADD: r_d = stk_rd_q + b_q;
                  fse_pkg::CMD_SUB: r_d = stk_rd_q - b_q;
                  fse_pkg::CMD_MUL: r_d = 32'(stk_rd_q * b_q);
                  fse_pkg::CMD_AND: r_d = stk_rd_q & b_q;
                  fse_pkg::CMD_OR:  r_d = stk_rd_q | b_q;
                  fse_pkg::CMD_XOR: r_d = stk_rd_q ^ b_q;
                  fse_pkg::CMD_SHL: r_d = stk_rd_q << sh;
                  fse_pkg::CMD_SHR: r_d = 32'($signed(stk_rd_q) >>> sh);
                  default: begin
                    dv_rem_d = '0;
                    dv_quo_d = rd_mag;
                    b_d      = b_mag;
                    dv_neg_d = stk_rd_q[31] ^ b_q[31];
                    dv_n_d   = 6'd32;
                    state_d  = S_DIV;
                  end
                endcase
              end
              default: begin
                stk_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
                if (mode_q) fp_d = fp_dec;
                fin = 1'b1;
              end
            endcase
          end
          fse_pkg::CMD_TUCK: begin
            case (ph_q)
              3'd0: begin
                stk_raddr = back0;
                if (cnt_q < CW'(2)) begin
                  st_d = fse_pkg::ST_UNDER;
                  fin  = 1'b1;
                end else if (cnt_q == CW'(STACK_DEPTH)) begin
                  st_d = fse_pkg::ST_OVER;
                  fin  = 1'b1;
                end
              end
              3'd1: begin
                a_d       = stk_rd_q;
                stk_raddr = back1;
              end
              3'd2: begin
                stk_we    = 1'b1;
                stk_waddr = back1;
                stk_wdata = a_q;
                b_d       = stk_rd_q;
              end
              3'd3: begin
                stk_we    = 1'b1;
                stk_waddr = back0;
                stk_wdata = b_q;
              end
              default: begin
                stk_we    = 1'b1;
                stk_waddr = slot_f(fp_q, cnt_q);
                stk_wdata = a_q;
                cnt_d     = cnt_q + 1'b1;
                fin       = 1'b1;
              end
            endcase
          end
          fse_pkg::CMD_PICK: begin
            if (ph_q == 3'd0) begin
              stk_raddr = slot_f(fp_q, bpos(cnt_q, opnd_q[PW-1:0]));
              if (idx_bad) begin
                st_d = fse_pkg::ST_INDEX;
                fin  = 1'b1;
              end else if (cnt_q == CW'(STACK_DEPTH)) begin
                st_d = fse_pkg::ST_OVER;
                fin  = 1'b1;
              end
            end else begin
              stk_we    = 1'b1;
              stk_wdata = stk_rd_q;
              cnt_d     = cnt_q + 1'b1;
              if (mode_q) fp_d = fp_dec;
              fin = 1'b1;
            end
          end
          fse_pkg::CMD_ROLL: begin
            case (ph_q)
              3'd0: begin
                stk_raddr = slot_f(fp_q, bpos(cnt_q, opnd_q[PW-1:0]));
                k_d       = opnd_q[PW-1:0];
                if (idx_bad) begin
                  st_d = fse_pkg::ST_INDEX;
                  fin  = 1'b1;
                end
              end
              3'd1: begin
                a_d       = stk_rd_q;
                stk_raddr = slot_f(fp_q, bpos(cnt_q, k_q - 1'b1));
                ph_d      = (k_q == '0) ? 3'd3 : 3'd2;
              end
              3'd2: begin
                // Shift one element toward the back while fetching the next one.
                stk_we    = 1'b1;
                stk_waddr = slot_f(fp_q, bpos(cnt_q, k_q));
                stk_wdata = stk_rd_q;
                stk_raddr = slot_f(fp_q, bpos(cnt_q, k_q - PW'(2)));
                k_d       = k_q - 1'b1;
                ph_d      = (k_q == PW'(1)) ? 3'd3 : 3'd2;
              end
              default: begin
                stk_we    = 1'b1;
                stk_waddr = back0;
                stk_wdata = a_q;
                fin       = 1'b1;
              end
            endcase
          end
          fse_pkg::CMD_OVER2: begin
            case (ph_q)
              3'd0, 3'd2: begin
                stk_raddr = back3;
                // The room check covers both pushes, so it is made before the first one only.
                if (ph_q == 3'd0) begin
                  if (cnt_q < CW'(4)) begin
                    st_d = fse_pkg::ST_UNDER;
                    fin  = 1'b1;
                  end else if (32'(cnt_q) + 32'd2 > 32'(STACK_DEPTH)) begin
                    st_d = fse_pkg::ST_OVER;
                    fin  = 1'b1;
                  end
                end
              end
              default: begin
                stk_we    = 1'b1;
                stk_wdata = stk_rd_q;
                cnt_d     = cnt_q + 1'b1;
                if (mode_q) fp_d = fp_dec;
                fin = (ph_q == 3'd3);
              end
            endcase
          end
          fse_pkg::CMD_DROP2: begin
            fin = 1'b1;
            if (cnt_q < CW'(2)) st_d = fse_pkg::ST_UNDER;
            else cnt_d = cnt_q - CW'(2);
          end
          fse_pkg::CMD_SWAP2: begin
            case (ph_q)
              3'd0: begin
                stk_raddr = back0;
                if (cnt_q < CW'(4)) begin
                  st_d = fse_pkg::ST_UNDER;
                  fin  = 1'b1;
                end
              end
              3'd1: begin
                a_d       = stk_rd_q;
                stk_raddr = back2;
              end
              3'd2: begin
                stk_we    = 1'b1;
                stk_waddr = back0;
                stk_wdata = stk_rd_q;
                stk_raddr = back1;
              end
              3'd3: begin
                stk_we    = 1'b1;
                stk_waddr = back2;
                stk_wdata = a_q;
                a_d       = stk_rd_q;
                stk_raddr = back3;
              end
              3'd4: begin
                stk_we    = 1'b1;
                stk_waddr = back1;
                stk_wdata = stk_rd_q;
              end
              default: begin
                stk_we    = 1'b1;
                stk_waddr = back3;
                stk_wdata = a_q;
                fin       = 1'b1;
              end
            endcase
          end
          fse_pkg::CMD_STORE: begin
            case (ph_q)
              3'd0: begin
                if (cnt_q < CW'(2)) begin
                  st_d = fse_pkg::ST_UNDER;
                  fin  = 1'b1;
                end else begin
                  cnt_d = cnt_q - 1'b1;
                  if (mode_q) fp_d = fp_inc;
                end
              end
              3'd1: begin
                a_d   = stk_rd_q;
                cnt_d = cnt_q - 1'b1;
                if (mode_q) fp_d = fp_inc;
              end
              default: begin
                fin = 1'b1;
                if (addr_bad) st_d = fse_pkg::ST_ADDR;
                else dm_we = 1'b1;
              end
            endcase
          end
          fse_pkg::CMD_LOAD: begin
            case (ph_q)
              3'd0: begin
                if (cnt_q == '0) begin
                  st_d = fse_pkg::ST_UNDER;
                  fin  = 1'b1;
                end else begin
                  cnt_d = cnt_q - 1'b1;
                  if (mode_q) fp_d = fp_inc;
                end
              end
              3'd1: begin
                a_d = stk_rd_q;
              end
              3'd2: begin
                if (addr_bad) begin
                  st_d = fse_pkg::ST_ADDR;
                  fin  = 1'b1;
                end
              end
              default: begin
                stk_we    = 1'b1;
                stk_wdata = dm_rd_q;
                cnt_d     = cnt_q + 1'b1;
                if (mode_q) fp_d = fp_dec;
                fin = 1'b1;
              end
            endcase
            dm_raddr = a_q[DAW-1:0];
          end
          default: fin = 1'b1;
        endcase
        if (fin) state_d = S_DONE;
      end
      S_DIV: begin
        dv_rem_d = rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];
        dv_quo_d = quo_nx;
        dv_n_d   = dv_n_q - 1'b1;
        if (dv_n_q == 6'd1) begin
          r_d     = dv_neg_q ? 32'(-quo_nx) : quo_nx;
          state_d = S_EXEC;
          ph_d    = 3'd3;
        end
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ph_q        <= '0;
      fp_q        <= '0;
      cnt_q       <= '0;
      mode_q      <= 1'b0;
      clr_q       <= '0;
      dv_n_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      fp_q    <= fp_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      dv_n_q  <= dv_n_d;
      if (cfg_valid_i && cfg_ready_o) mode_q <= front_mode_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= command_i;
      opnd_q <= operand_i;
    end
    a_q      <= a_d;
    b_q      <= b_d;
    r_q      <= r_d;
    k_q      <= k_d;
    st_q     <= st_d;
    pv_q     <= pv_d;
    dv_rem_q <= dv_rem_d;
    dv_quo_q <= dv_quo_d;
    dv_neg_q <= dv_neg_d;
    if (out_load) begin
      out_st_q    <= st_q;
      out_pv_q    <= pv_q;
      out_depth_q <= cnt_q;
    end
  end

  // Stack memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rd_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) dmem[dm_waddr] <= dm_wdata;
    dm_rd_q <= dmem[dm_raddr];
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("element count exceeds stack depth");

  a_fp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fp_q <= PW'(STACK_DEPTH - 1))
    else $error("front pointer outside ring");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside completion");

  a_div_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cmd_q == fse_pkg::CMD_DIV)
    else $error("divider running for a non-divide command");
`endif

endmodule
